// ===== hdl/btrr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// btrr_pkg
// Shared types and constants of the bitmap text row renderer.
// ----------------------------------------------------------------------------
package btrr_pkg;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_DRAW  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] MODE_CONT   = 2'd0;
  localparam logic [1:0] MODE_START  = 2'd1;
  localparam logic [1:0] MODE_CURSOR = 2'd2;

  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] FIRST_CODE = 8'h20;
  localparam logic [7:0] LAST_CODE  = 8'h7E;

  localparam logic [16:0] GLYPH_SIZE  = 17'd18;
  localparam logic [15:0] LINE_PITCH  = 16'd20;
  localparam logic [11:0] GLYPH_BYTES = 12'd41;
  localparam logic [4:0]  READ_PAIRS  = 5'd21;
  localparam logic [4:0]  LAST_PAIR   = 5'd20;
  localparam logic [4:0]  LAST_ROW    = 5'd17;
  localparam logic [6:0]  ROW_BITS    = 7'd18;
  localparam logic [6:0]  PAIR_BITS   = 7'd16;
  localparam logic [7:0]  BUF_BITS    = 8'd64;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic REG_TEXT_COLOR       = 1'b0;
  localparam logic REG_BACKGROUND_COLOR = 1'b1;

  typedef struct packed {
    logic        is_load;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [15:0] pen_x;
    logic [15:0] pen_y;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_DRAW
  } back_state_t;

endpackage
`default_nettype wire

// ===== hdl/btrr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// btrr_front
// Input side: accepts items, tracks the pen and queues loads and glyph draws.
// ----------------------------------------------------------------------------
module btrr_front #(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 240
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  input  wire  [63:0]         s_tdata,   // font_addr, font_byte, char_code, begin_mode,
                                         // start_x, start_y
  input  wire  [1:0]          s_tuser,   // func
  input  wire                 q_full,
  output logic                q_push,
  output btrr_pkg::cmd_t      q_cmd
);
  import btrr_pkg::*;

  logic [15:0] pen_x;
  logic [15:0] pen_y;
  logic [15:0] line_start_x;
  logic        stopped;

  logic [15:0] pen_x_next;
  logic [15:0] pen_y_next;
  logic [15:0] line_start_x_next;
  logic        stopped_next;
  logic        enq;
  logic        accept;

  logic [11:0] font_addr;
  logic [7:0]  font_byte;
  logic [7:0]  char_code;
  logic [1:0]  begin_mode;
  logic [15:0] start_x;
  logic [15:0] start_y;

  assign font_addr  = s_tdata[11:0];
  assign font_byte  = s_tdata[19:12];
  assign char_code  = s_tdata[27:20];
  assign begin_mode = s_tdata[29:28];
  assign start_x    = s_tdata[45:30];
  assign start_y    = s_tdata[61:46];

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign q_push   = accept && enq;

  always_comb begin
    logic       active;
    logic [6:0] glyph;
    active            = 1'b0;
    glyph             = '0;
    pen_x_next        = pen_x;
    pen_y_next        = pen_y;
    line_start_x_next = line_start_x;
    stopped_next      = stopped;
    enq               = 1'b0;
    q_cmd             = '0;
    unique case (s_tuser)
      FUNC_LOAD: begin
        enq           = 1'b1;
        q_cmd.is_load = 1'b1;
        q_cmd.addr    = font_addr;
        q_cmd.data    = font_byte;
      end
      FUNC_CLEAR: begin
        pen_x_next = '0;
        pen_y_next = '0;
      end
      FUNC_DRAW: begin
        active = 1'b1;
        if (begin_mode == MODE_START) begin
          pen_x_next        = start_x;
          pen_y_next        = start_y;
          line_start_x_next = start_x;
          stopped_next      = 1'b0;
        end else if (begin_mode == MODE_CURSOR) begin
          line_start_x_next = pen_x;
          stopped_next      = 1'b0;
        end else if (stopped) begin
          active = 1'b0;
        end
        if (active) begin
          if (char_code == CHAR_NL) begin
            pen_x_next = line_start_x_next;
            pen_y_next = pen_y_next + LINE_PITCH;
          end else if (char_code == CHAR_CR) begin
            pen_x_next = line_start_x_next;
          end else begin
            if ({1'b0, pen_x_next} + GLYPH_SIZE > 17'(SCREEN_WIDTH)) begin
              pen_x_next = line_start_x_next;
              pen_y_next = pen_y_next + LINE_PITCH;
            end
            if (char_code >= FIRST_CODE && char_code <= LAST_CODE) begin
              glyph = 7'(char_code - FIRST_CODE);
            end
            enq         = 1'b1;
            q_cmd.addr  = 12'(glyph) * GLYPH_BYTES;
            q_cmd.pen_x = pen_x_next;
            q_cmd.pen_y = pen_y_next;
            pen_x_next  = pen_x_next + 16'(GLYPH_SIZE);
          end
          if ({1'b0, pen_y_next} + GLYPH_SIZE > 17'(SCREEN_HEIGHT)) begin
            stopped_next = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x        <= '0;
      pen_y        <= '0;
      line_start_x <= '0;
      stopped      <= 1'b0;
    end else if (accept) begin
      pen_x        <= pen_x_next;
      pen_y        <= pen_y_next;
      line_start_x <= line_start_x_next;
      stopped      <= stopped_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/btrr_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// btrr_queue
// Short command queue between the pen tracker and the row generator.
// ----------------------------------------------------------------------------
module btrr_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  btrr_pkg::cmd_t      push_cmd,
  output logic                full,
  input  wire                 pop,
  output logic                head_valid,
  output btrr_pkg::cmd_t      head_cmd
);
  import btrr_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/btrr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// btrr_back
// Row generator: owns the font store, streams glyph bytes two per cycle while
// the bit buffer has room and emits eighteen clipped rows per character.
// ----------------------------------------------------------------------------
module btrr_back #(
  parameter int SCREEN_WIDTH     = 240,
  parameter int SCREEN_HEIGHT    = 240,
  parameter int FONT_STORE_BYTES = 4096
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 q_valid,
  input  btrr_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  input  wire  [15:0]         text_color,
  input  wire  [15:0]         background_color,
  output logic                m_tvalid,
  input  wire                 m_tready,
  output logic [103:0]        m_tdata,   // row_x, row_y, glyph_bits, visible_mask,
                                         // ink_color, paper_color
  output logic                m_tlast
);
  import btrr_pkg::*;

  localparam int AW = $clog2(FONT_STORE_BYTES);

  logic [7:0] font_mem [FONT_STORE_BYTES];

  back_state_t state;
  back_state_t state_next;

  logic [15:0] cur_x;
  logic [15:0] cur_y;
  logic [11:0] cur_base;
  logic [4:0]  rd_idx;
  logic        rd_pend;
  logic [7:0]  rd0;
  logic [7:0]  rd1;
  logic [63:0] bitbuf;
  logic [6:0]  cnt;
  logic [4:0]  row;

  logic [15:0] row_x;
  logic [15:0] row_y;
  logic [17:0] glyph_bits;
  logic [17:0] visible_mask;
  logic [15:0] ink_color;
  logic [15:0] paper_color;

  logic        pop_row;
  logic        last_pop;
  logic        issue;
  logic        start_draw;
  logic        mem_we;
  logic [11:0] ra0;
  logic [11:0] ra1;
  logic [6:0]  cnt_a;
  logic [63:0] buf_a;
  logic [15:0] py;
  logic [17:0] vis;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid && !q_cmd.is_load) begin
          state_next = BK_DRAW;
        end
      end
      BK_DRAW: begin
        if (last_pop) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    start_draw = 1'b0;
    mem_we     = 1'b0;
    pop_row    = 1'b0;
    issue      = 1'b0;
    unique case (state)
      BK_IDLE: begin
        q_pop      = q_valid;
        start_draw = q_valid && !q_cmd.is_load;
        mem_we     = q_valid && q_cmd.is_load && (int'(q_cmd.addr) < FONT_STORE_BYTES);
      end
      BK_DRAW: begin
        pop_row = (cnt >= ROW_BITS) && (!m_tvalid || m_tready);
        issue   = (rd_idx < READ_PAIRS) &&
                  (8'(cnt) + (rd_pend ? 8'(PAIR_BITS) : 8'd0) + 8'(PAIR_BITS) <= BUF_BITS);
      end
      default: begin
      end
    endcase
  end

  assign last_pop = pop_row && (row == LAST_ROW);

  assign ra0 = cur_base + {6'd0, rd_idx, 1'b0};
  assign ra1 = (rd_idx == LAST_PAIR) ? ra0 : ra0 + 12'd1;

  assign cnt_a = pop_row ? cnt - ROW_BITS : cnt;
  assign buf_a = pop_row ? (bitbuf << ROW_BITS) : bitbuf;

  assign py = cur_y + {11'd0, row};

  always_comb begin
    logic [15:0] px;
    for (int col = 0; col < 18; col++) begin
      px           = cur_x + 16'(col);
      vis[17 - col] = ({1'b0, px} < 17'(SCREEN_WIDTH)) && ({1'b0, py} < 17'(SCREEN_HEIGHT));
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      font_mem[AW'(q_cmd.addr)] <= q_cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd0 <= font_mem[AW'(ra0)];
      rd1 <= font_mem[AW'(ra1)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_IDLE;
      rd_pend <= 1'b0;
      rd_idx  <= '0;
      row     <= '0;
      cnt     <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;
      if (start_draw) begin
        rd_idx <= '0;
        row    <= '0;
        cnt    <= '0;
      end else begin
        if (issue) begin
          rd_idx <= rd_idx + 5'd1;
        end
        if (pop_row) begin
          row <= row + 5'd1;
        end
        cnt <= rd_pend ? cnt_a + PAIR_BITS : cnt_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_draw) begin
      cur_x    <= q_cmd.pen_x;
      cur_y    <= q_cmd.pen_y;
      cur_base <= q_cmd.addr;
      bitbuf   <= '0;
    end else if (rd_pend) begin
      bitbuf <= buf_a | ({rd0, rd1, 48'd0} >> cnt_a);
    end else begin
      bitbuf <= buf_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop_row) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_row) begin
      row_x        <= cur_x;
      row_y        <= py;
      glyph_bits   <= bitbuf[63:46];
      visible_mask <= vis;
      ink_color    <= text_color;
      paper_color  <= background_color;
      m_tlast      <= (row == LAST_ROW);
    end
  end

  assign m_tdata = {4'd0, paper_color, ink_color, visible_mask, glyph_bits, row_y, row_x};

  a_reads_done: assert property (@(posedge clk) disable iff (rst)
    last_pop |-> (!rd_pend && rd_idx == READ_PAIRS))
    else $error("character finished with font reads outstanding");

  a_room_for_data: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (cnt <= 7'd48))
    else $error("bit buffer lacks room for arriving font bytes");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DRAW) |-> (row <= LAST_ROW))
    else $error("row counter ran past the last glyph row");

  a_idle_no_rows: assert property (@(posedge clk) disable iff (rst)
    (state == BK_IDLE) |=> !$rose(m_tvalid) || $past(pop_row))
    else $error("row emitted without a draw in progress");

endmodule
`default_nettype wire

// ===== hdl/bitmap_text_row_renderer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_text_row_renderer
// Character stream to 18x18 glyph rows for a framebuffer writer.
// ----------------------------------------------------------------------------
// Input beats arrive on s_*: s_tuser selects font load, character or cursor
// clear. The front tracks the pen for each accepted beat and queues font loads
// and glyph draws in a four-entry queue; newline, return, cursor clear and
// ignored characters never reach the queue.
// The row generator writes font loads into the font store while idle. A drawn
// character reads two font bytes per cycle from the dual-read font store while
// its bit buffer has room, fetching the 41 glyph bytes in 21 pair reads.
// Its 18 rows leave on m_* through an output register, m_tlast marking the
// eighteenth. When m_tready is low the output register holds, the generator
// stops, the queue fills and s_tready drops once four commands wait.
// Reset clears the pen, the queue, the generator and the colors (text white,
// background black). The font store is not cleared and must be loaded before
// glyphs are drawn. Colors must be written on cfg_* by the user while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module bitmap_text_row_renderer #(
  parameter int SCREEN_WIDTH     = 240,
  parameter int SCREEN_HEIGHT    = 240,
  parameter int FONT_STORE_BYTES = 4096
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [63:0]  s_tdata,   // font_addr[11:0], font_byte[19:12], char_code[27:20],
                                  // begin_mode[29:28], start_x[45:30], start_y[61:46]
  input  wire  [1:0]   s_tuser,   // func[1:0]
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [103:0] m_tdata,   // row_x[15:0], row_y[31:16], glyph_bits[49:32],
                                  // visible_mask[67:50], ink_color[83:68],
                                  // paper_color[99:84]
  output logic         m_tlast,
  input  wire          cfg_we,
  input  wire          cfg_index,
  input  wire  [15:0]  cfg_wdata
);
  import btrr_pkg::*;

  logic [15:0] text_color;
  logic [15:0] background_color;

  logic        q_full;
  logic        q_push;
  cmd_t        push_cmd;
  logic        q_pop;
  logic        head_valid;
  cmd_t        head_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color       <= 16'hFFFF;
      background_color <= 16'h0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEXT_COLOR:       text_color       <= cfg_wdata;
        REG_BACKGROUND_COLOR: background_color <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  btrr_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  btrr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  btrr_back #(
    .SCREEN_WIDTH     (SCREEN_WIDTH),
    .SCREEN_HEIGHT    (SCREEN_HEIGHT),
    .FONT_STORE_BYTES (FONT_STORE_BYTES)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (head_valid),
    .q_cmd            (head_cmd),
    .q_pop            (q_pop),
    .text_color       (text_color),
    .background_color (background_color),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tlast          (m_tlast)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_bitmap_text_row_renderer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_text_row_renderer
// Self-checking bench for the bitmap text row renderer.
// A few glyphs are loaded into the font store. Directed strings then cover
// the screen edges, the right-edge wrap, the bottom stop, cursor restarts and
// pen wrap-around. Random strings and noise follow under several color
// settings. A scoreboard keeps its own pen, font copy and colors. It predicts
// the eighteen rows of each drawn character and checks every output beat
// against them in order. Both stream sides idle at random, and the output
// side holds off for one long stretch to back the block up.
// ----------------------------------------------------------------------------
module tb_bitmap_text_row_renderer;
  import btrr_pkg::*;

  localparam int SCREEN_W     = 240;
  localparam int SCREEN_H     = 240;
  localparam int FONT_BYTES   = 4096;
  localparam int GLYPH        = int'(GLYPH_SIZE);
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 54;
  localparam int HOLD_CYCLES  = 500;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam logic [1:0] MODE_ALT  = 2'd3;

  // codes whose glyphs are loaded before any drawing
  localparam logic [31:0] LOADED_CODES = {8'h7E, 8'h41, 8'h21, 8'h20};

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [17:0] bits;
    logic [17:0] mask;
    logic [15:0] ink;
    logic [15:0] paper;
    logic        last;
  } glyph_row_t;

  class glyph_row_scoreboard;
    logic [15:0] ink;
    logic [15:0] paper;
    logic [15:0] pen_x;
    logic [15:0] pen_y;
    logic [15:0] line_x;
    logic        stopped;
    logic [7:0]  font_copy [FONT_BYTES];
    glyph_row_t  rows_due [$];
    int          errors;

    function new();
      ink     = 16'hFFFF;
      paper   = 16'h0000;
      pen_x   = '0;
      pen_y   = '0;
      line_x  = '0;
      stopped = 1'b0;
      errors  = 0;
      foreach (font_copy[i]) font_copy[i] = '0;
    endfunction

    function void set_color(logic idx, logic [15:0] value);
      if (idx == REG_TEXT_COLOR) ink = value;
      else paper = value;
    endfunction

    // returns 1 when the beat changes state or draws
    function bit note_input(logic [1:0] func, logic [63:0] data);
      logic [11:0] addr;
      logic [7:0]  code;
      logic [1:0]  mode;
      logic [7:0]  fbyte;
      logic [15:0] px;
      glyph_row_t  r;
      int          glyph;
      int          n;
      addr = data[11:0];
      code = data[27:20];
      mode = data[29:28];
      if (func == FUNC_LOAD) begin
        if (addr < FONT_BYTES) font_copy[addr] = data[19:12];
        return 1'b1;
      end
      if (func == FUNC_CLEAR) begin
        pen_x = '0;
        pen_y = '0;
        return 1'b1;
      end
      if (func != FUNC_DRAW) return 1'b0;

      if (mode == MODE_START) begin
        pen_x   = data[45:30];
        pen_y   = data[61:46];
        line_x  = pen_x;
        stopped = 1'b0;
      end else if (mode == MODE_CURSOR) begin
        line_x  = pen_x;
        stopped = 1'b0;
      end else if (stopped) begin
        return 1'b0;
      end

      if (code == CHAR_NL) begin
        pen_x = line_x;
        pen_y = pen_y + LINE_PITCH;
      end else if (code == CHAR_CR) begin
        pen_x = line_x;
      end else begin
        if (int'(pen_x) + GLYPH > SCREEN_W) begin
          pen_x = line_x;
          pen_y = pen_y + LINE_PITCH;
        end
        glyph = (code >= FIRST_CODE && code <= LAST_CODE) ?
                int'(code) - int'(FIRST_CODE) : 0;
        for (int row = 0; row < GLYPH; row++) begin
          r.x     = pen_x;
          r.y     = pen_y + 16'(row);
          r.bits  = '0;
          r.mask  = '0;
          r.ink   = ink;
          r.paper = paper;
          r.last  = (row == GLYPH - 1);
          for (int col = 0; col < GLYPH; col++) begin
            n     = row * GLYPH + col;
            fbyte = font_copy[glyph * int'(GLYPH_BYTES) + n / 8];
            px    = pen_x + 16'(col);
            r.bits[GLYPH-1-col] = fbyte[7 - n % 8];
            r.mask[GLYPH-1-col] = (px < SCREEN_W) && (r.y < SCREEN_H);
          end
          rows_due.push_back(r);
        end
        pen_x = pen_x + 16'(GLYPH);
      end
      if (int'(pen_y) + GLYPH > SCREEN_H) stopped = 1'b1;
      return 1'b1;
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_row(logic [103:0] data, logic last);
      glyph_row_t e;
      if (rows_due.size() == 0) begin
        $error("output beat with no row due: tdata=%h tlast=%b", data, last);
        errors++;
        return;
      end
      e = rows_due.pop_front();
      check_field("row_x", e.x, data[15:0]);
      check_field("row_y", e.y, data[31:16]);
      check_field("glyph_bits", e.bits, data[49:32]);
      check_field("visible_mask", e.mask, data[67:50]);
      check_field("ink_color", e.ink, data[83:68]);
      check_field("paper_color", e.paper, data[99:84]);
      check_field("last_row", e.last, last);
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [63:0]  s_tdata = '0;
  logic [1:0]   s_tuser = FUNC_LOAD;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic         m_tlast;
  logic         cfg_we = 1'b0;
  logic         cfg_index = REG_TEXT_COLOR;
  logic [15:0]  cfg_wdata = '0;

  glyph_row_scoreboard sb;
  int burst_left = 1;
  int taken = 0;
  int hold_at = 32'h7FFF_FFFF;
  bit hold_fired = 1'b0;
  int hold_left = 0;
  int ready_style = 0;
  int cycle_count = 0;

  bitmap_text_row_renderer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] pack_item(logic [11:0] addr, logic [7:0] fbyte,
                                            logic [7:0] code, logic [1:0] mode,
                                            logic [15:0] sx, logic [15:0] sy);
    return {2'b00, sy, sx, mode, code, fbyte, addr};
  endfunction

  function automatic logic [63:0] random_fields();
    return pack_item(12'($urandom), 8'($urandom), 8'($urandom), 2'($urandom),
                     16'($urandom), 16'($urandom));
  endfunction

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 9))
      0: return CHAR_NL;
      1: return CHAR_CR;
      2, 3: return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 31)) :
                                                 8'($urandom_range(127, 255));
      default: return LOADED_CODES[8*$urandom_range(0, 3) +: 8];
    endcase
  endfunction

  // hold the beat until taken, then continue the burst or drop valid for a gap
  task automatic send_beat(logic [1:0] func, logic [63:0] data);
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    if (sb.note_input(func, data)) taken++;
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
                                                 $urandom_range(1, 8);
    end
  endtask

  task automatic send_char(logic [1:0] mode, logic [7:0] code,
                           logic [15:0] sx = '0, logic [15:0] sy = '0);
    send_beat(FUNC_DRAW, pack_item(12'($urandom), 8'($urandom), code, mode, sx, sy));
  endtask

  task automatic send_load(logic [11:0] addr, logic [7:0] fbyte);
    send_beat(FUNC_LOAD, pack_item(addr, fbyte, 8'($urandom), 2'($urandom),
                                   16'($urandom), 16'($urandom)));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.rows_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_colors(logic [15:0] ink, logic [15:0] paper);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TEXT_COLOR;
    cfg_wdata <= ink;
    @(negedge clk);
    cfg_index <= REG_BACKGROUND_COLOR;
    cfg_wdata <= paper;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_color(REG_TEXT_COLOR, ink);
    sb.set_color(REG_BACKGROUND_COLOR, paper);
  endtask

  initial begin
    int          start;
    int          len;
    logic [1:0]  mode;
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int g = 0; g < 4; g++) begin
      for (int i = 0; i < int'(GLYPH_BYTES); i++) begin
        send_load(12'((int'(LOADED_CODES[8*g +: 8]) - int'(FIRST_CODE)) *
                      int'(GLYPH_BYTES) + i), 8'($urandom));
      end
    end

    send_char(MODE_START, 8'h41, 16'd0, 16'd0);
    send_char(MODE_CONT, LAST_CODE);
    send_char(MODE_CONT, 8'h00);
    send_char(MODE_CONT, 8'hFF);
    send_char(MODE_CONT, 8'h7F);
    send_char(MODE_CONT, 8'h1F);
    send_char(MODE_CONT, CHAR_CR);
    send_char(MODE_CONT, CHAR_NL);
    send_char(MODE_CONT, FIRST_CODE);
    send_char(MODE_START, 8'h41, 16'd230, 16'd40);
    send_char(MODE_START, 8'h21, 16'd222, 16'd80);
    send_char(MODE_CONT, 8'h21);
    send_char(MODE_START, 8'h41, 16'd0, 16'd222);
    send_char(MODE_CONT, CHAR_NL);
    send_char(MODE_CONT, 8'h41);
    send_char(MODE_CONT, CHAR_CR);
    send_char(MODE_CURSOR, 8'h41);
    send_beat(FUNC_CLEAR, '0);
    send_char(MODE_ALT, 8'h21);
    send_char(MODE_CURSOR, 8'h21);
    send_beat(FUNC_NONE, {2'b00, {62{1'b1}}});
    send_load(12'hFFF, 8'hFF);
    send_load(12'h000, 8'h00);
    send_char(MODE_START, 8'h80, 16'hFFF8, 16'hFFFA);
    send_char(MODE_START, 8'h41, 16'hFFFF, 16'hFFFF);

    for (int p = 0; p < 5; p++) begin
      wait_drained();
      case (p)
        0: write_colors(16'h0000, 16'hFFFF);
        1: write_colors(16'hFFFF, 16'hFFFF);
        2: write_colors(16'h0000, 16'h0000);
        default: write_colors(16'($urandom), 16'($urandom));
      endcase
      start = taken;
      if (p == 1) hold_at = taken + 30;
      while (taken - start < PHASE_ITEMS) begin
        case ($urandom_range(0, 19))
          0: send_load(12'($urandom), 8'($urandom));
          1: send_beat(FUNC_CLEAR, random_fields());
          2: send_beat(FUNC_NONE, random_fields());
          3: send_char(2'($urandom), pick_code(), 16'($urandom), 16'($urandom));
          default: begin
            mode = ($urandom_range(0, 3) == 0) ? MODE_CURSOR : MODE_START;
            send_char(mode, pick_code(), 16'($urandom_range(0, 239)),
                      16'($urandom_range(0, 239)));
            len = $urandom_range(2, 14);
            for (int k = 0; k < len; k++) begin
              send_char(MODE_CONT, pick_code(), 16'($urandom), 16'($urandom));
            end
          end
        endcase
      end
    end

    wait_drained();
    if (sb.errors == 0 && sb.rows_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (!hold_fired && taken >= hold_at) begin
      hold_fired = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (cycle_count % 64 == 0) ready_style = $urandom_range(0, 2);
    cycle_count++;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (ready_style)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_row(m_tdata, m_tlast);
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
